// ===== design/wlz_pkg.sv =====
package wlz_pkg;

  localparam int LAYER_COUNT = 256;
  localparam int LW          = $clog2(LAYER_COUNT);
  localparam int CW          = LW + 1;

  localparam logic [2:0] FN_ALLOC   = 3'd0;
  localparam logic [2:0] FN_SIZE    = 3'd1;
  localparam logic [2:0] FN_LEVEL   = 3'd2;
  localparam logic [2:0] FN_MOVE    = 3'd3;
  localparam logic [2:0] FN_REFRESH = 3'd4;
  localparam logic [2:0] FN_FREE    = 3'd5;

  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_SCAN,
    ST_SH_RD,
    ST_SH_WR,
    ST_FINISH,
    ST_MOVE_WAIT,
    ST_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [7:0]         layer;
    logic signed [12:0] pos_x;
    logic signed [12:0] pos_y;
    logic [12:0]        width;
    logic [12:0]        height_px;
    logic signed [10:0] new_level;
    logic signed [8:0]  key_color;
    logic [11:0]        rect_x0;
    logic [11:0]        rect_y0;
    logic [11:0]        rect_x1;
    logic [11:0]        rect_y1;
  } item_t;

  typedef struct packed {
    logic signed [12:0] ox;
    logic signed [12:0] oy;
    logic [12:0]        sx;
    logic [12:0]        sy;
    logic signed [8:0]  key;
  } attr_t;

  typedef struct packed {
    logic [12:0] w;
    logic [12:0] h;
  } screen_t;

  typedef struct packed {
    logic signed [14:0] x0;
    logic signed [14:0] y0;
    logic signed [14:0] x1;
    logic signed [14:0] y1;
  } rect_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  given_layer;
    logic        dirty_valid;
    logic [12:0] dirty_x0;
    logic [12:0] dirty_y0;
    logic [12:0] dirty_x1;
    logic [12:0] dirty_y1;
    logic        last;
  } result_t;

endpackage

// ===== design/wlz_clip.sv =====
module wlz_clip (
  input  wlz_pkg::rect_t   rect,
  input  wlz_pkg::screen_t scr,
  input  logic             last,
  output wlz_pkg::result_t res
);
  import wlz_pkg::*;

  logic signed [14:0] sw, sh, x0c, y0c, x1c, y1c;
  logic               hit;

  assign sw  = $signed({2'b00, scr.w});
  assign sh  = $signed({2'b00, scr.h});
  assign x0c = (rect.x0 < 15'sd0) ? 15'sd0 : rect.x0;
  assign y0c = (rect.y0 < 15'sd0) ? 15'sd0 : rect.y0;
  assign x1c = (rect.x1 > sw) ? sw : rect.x1;
  assign y1c = (rect.y1 > sh) ? sh : rect.y1;
  assign hit = (x0c < x1c) && (y0c < y1c);

  always_comb begin
    res             = '0;
    res.last        = last;
    res.dirty_valid = hit;
    if (hit) begin
      res.dirty_x0 = x0c[12:0];
      res.dirty_y0 = y0c[12:0];
      res.dirty_x1 = x1c[12:0];
      res.dirty_y1 = y1c[12:0];
    end
  end

endmodule

// ===== design/wlz_core.sv =====
module wlz_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  wlz_pkg::item_t   item,
  input  wlz_pkg::screen_t scr,
  output logic             out_valid,
  input  logic             out_stall,
  output wlz_pkg::result_t res
);
  import wlz_pkg::*;

  state_t state, state_next;
  item_t  it;

  logic [LAYER_COUNT-1:0] in_use, attr_ok_bits;
  logic [7:0]             stack_mem [LAYER_COUNT];
  logic signed [8:0]      level_mem [LAYER_COUNT];
  attr_t                  attr_mem  [LAYER_COUNT];

  logic [7:0]        stack_rd;
  logic signed [8:0] level_rd;
  attr_t             attr_rd, attr_e;
  logic              attr_ok;

  logic signed [8:0] top_lvl, req;
  logic [CW-1:0]     cnt, stop;
  logic              down;

  logic              stk_we, lv_we, at_we;
  logic [LW-1:0]     stk_wa, stk_ra, lv_wa;
  logic [7:0]        stk_wd;
  logic signed [8:0] lv_wd;
  attr_t             at_wd;

  logic              load_res;
  result_t           res_next, clip_res;
  rect_t             rect;
  logic              clip_last;

  logic              used, bad, shown, changed, scan_free, out_take;
  logic signed [10:0] rq, lim, req11;
  logic signed [8:0] req_c;

  assign in_stall = (state != ST_IDLE);
  assign out_take = out_valid && !out_stall;
  assign attr_e   = attr_ok ? attr_rd : attr_t'{13'sd0, 13'sd0, 13'd0, 13'd0, -9'sd1};
  assign used     = in_use[it.layer[LW-1:0]];
  assign bad      = (it.func > FN_FREE) || !used;
  assign shown    = (level_rd >= 9'sd0);
  assign scan_free = !in_use[cnt[LW-1:0]];

  assign rq    = (it.func == FN_FREE) ? -11'sd1 : it.new_level;
  assign lim   = shown ? {{2{top_lvl[8]}}, top_lvl} : {{2{top_lvl[8]}}, top_lvl} + 11'sd1;
  assign req11 = (rq > lim) ? lim : ((rq < -11'sd1) ? -11'sd1 : rq);
  assign req_c = req11[8:0];
  assign changed = (req_c != level_rd);

  always_comb begin
    rect = '0;
    if (state == ST_MOVE_WAIT) begin
      rect.x0 = {{2{it.pos_x[12]}}, it.pos_x};
      rect.y0 = {{2{it.pos_y[12]}}, it.pos_y};
      rect.x1 = rect.x0 + $signed({2'b00, attr_e.sx});
      rect.y1 = rect.y0 + $signed({2'b00, attr_e.sy});
    end else if (it.func == FN_REFRESH) begin
      rect.x0 = {{2{attr_e.ox[12]}}, attr_e.ox} + $signed({3'b000, it.rect_x0});
      rect.y0 = {{2{attr_e.oy[12]}}, attr_e.oy} + $signed({3'b000, it.rect_y0});
      rect.x1 = {{2{attr_e.ox[12]}}, attr_e.ox} + $signed({3'b000, it.rect_x1}) + 15'sd1;
      rect.y1 = {{2{attr_e.oy[12]}}, attr_e.oy} + $signed({3'b000, it.rect_y1}) + 15'sd1;
    end else begin
      rect.x0 = {{2{attr_e.ox[12]}}, attr_e.ox};
      rect.y0 = {{2{attr_e.oy[12]}}, attr_e.oy};
      rect.x1 = rect.x0 + $signed({2'b00, attr_e.sx});
      rect.y1 = rect.y0 + $signed({2'b00, attr_e.sy});
    end
  end

  assign clip_last = !(state == ST_DECIDE && it.func == FN_MOVE);

  wlz_clip u_clip (
    .rect (rect),
    .scr  (scr),
    .last (clip_last),
    .res  (clip_res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_READ;
      ST_READ:      state_next = ST_DECIDE;
      ST_DECIDE: begin
        priority if (it.func == FN_ALLOC) state_next = ST_SCAN;
        else if (bad) state_next = ST_OUT_WAIT;
        else if ((it.func == FN_LEVEL && changed) || (it.func == FN_FREE && shown))
          state_next = ST_SH_RD;
        else if (it.func == FN_MOVE && shown) state_next = ST_MOVE_WAIT;
        else state_next = ST_OUT_WAIT;
      end
      ST_SCAN:      if (scan_free || cnt == CW'(LAYER_COUNT - 1)) state_next = ST_OUT_WAIT;
      ST_SH_RD:     state_next = (cnt == stop) ? ST_FINISH : ST_SH_WR;
      ST_SH_WR:     state_next = ST_SH_RD;
      ST_FINISH:    state_next = ST_OUT_WAIT;
      ST_MOVE_WAIT: if (out_take) state_next = ST_OUT_WAIT;
      ST_OUT_WAIT:  if (out_take) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    stk_we   = 1'b0;
    stk_wa   = cnt[LW-1:0];
    stk_wd   = stack_rd;
    stk_ra   = down ? LW'(cnt - CW'(1)) : LW'(cnt + CW'(1));
    lv_we    = 1'b0;
    lv_wa    = stack_rd[LW-1:0];
    lv_wd    = $signed(cnt);
    at_we    = 1'b0;
    at_wd    = attr_e;
    load_res = 1'b0;
    res_next = '0;
    res_next.last = 1'b1;
    unique case (state)
      ST_DECIDE: begin
        if (it.func != FN_ALLOC) begin
          if (bad) begin
            load_res = 1'b1;
          end else begin
            unique case (it.func)
              FN_SIZE: begin
                at_we = 1'b1;
                at_wd.sx  = it.width;
                at_wd.sy  = it.height_px;
                at_wd.key = it.key_color;
                load_res  = 1'b1;
              end
              FN_MOVE: begin
                at_we = 1'b1;
                at_wd.ox = it.pos_x;
                at_wd.oy = it.pos_y;
                load_res = 1'b1;
                if (shown) res_next = clip_res;
              end
              FN_REFRESH: begin
                load_res = 1'b1;
                if (shown) res_next = clip_res;
              end
              FN_LEVEL: load_res = !changed;
              FN_FREE:  load_res = !shown;
              default:  load_res = 1'b1;
            endcase
          end
        end
      end
      ST_SCAN: begin
        if (scan_free) begin
          lv_we    = 1'b1;
          lv_wa    = cnt[LW-1:0];
          lv_wd    = -9'sd1;
          load_res = 1'b1;
          res_next.given_layer = cnt[7:0];
        end else if (cnt == CW'(LAYER_COUNT - 1)) begin
          load_res = 1'b1;
          res_next.status = 1'b1;
        end
      end
      ST_SH_WR: begin
        stk_we = 1'b1;
        lv_we  = 1'b1;
      end
      ST_FINISH: begin
        lv_we    = 1'b1;
        lv_wa    = it.layer[LW-1:0];
        lv_wd    = req;
        stk_we   = (req >= 9'sd0);
        stk_wa   = req[LW-1:0];
        stk_wd   = it.layer;
        load_res = 1'b1;
        res_next = clip_res;
      end
      ST_MOVE_WAIT: begin
        load_res = out_take;
        res_next = clip_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    if (state == ST_SH_RD) stack_rd <= stack_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (lv_we) level_mem[lv_wa] <= lv_wd;
    if (state == ST_READ) level_rd <= level_mem[it.layer[LW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (at_we) attr_mem[it.layer[LW-1:0]] <= at_wd;
    if (state == ST_READ) attr_rd <= attr_mem[it.layer[LW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      in_use       <= '0;
      attr_ok_bits <= '0;
      top_lvl      <= -9'sd1;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (load_res) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
      if (at_we) attr_ok_bits[it.layer[LW-1:0]] <= 1'b1;
      if (state == ST_SCAN && scan_free) in_use[cnt[LW-1:0]] <= 1'b1;
      if (state == ST_DECIDE && it.func == FN_FREE && !bad)
        in_use[it.layer[LW-1:0]] <= 1'b0;
      if (state == ST_DECIDE && !bad && changed && shown && req_c < 9'sd0
          && (it.func == FN_LEVEL || it.func == FN_FREE))
        top_lvl <= top_lvl - 9'sd1;
      else if (state == ST_DECIDE && !bad && it.func == FN_LEVEL && changed && !shown)
        top_lvl <= top_lvl + 9'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) it <= item;
    if (load_res) res <= res_next;
    if (state == ST_READ) attr_ok <= attr_ok_bits[it.layer[LW-1:0]];
    unique case (state)
      ST_DECIDE: begin
        req <= req_c;
        cnt <= '0;
        if (it.func != FN_ALLOC) begin
          if (level_rd > req_c) begin
            if (req_c >= 9'sd0) begin
              down <= 1'b1;
              cnt  <= CW'(level_rd);
              stop <= CW'(req_c);
            end else begin
              down <= 1'b0;
              cnt  <= CW'(level_rd);
              stop <= CW'(top_lvl);
            end
          end else if (shown) begin
            down <= 1'b0;
            cnt  <= CW'(level_rd);
            stop <= CW'(req_c);
          end else begin
            down <= 1'b1;
            cnt  <= CW'(top_lvl + 9'sd1);
            stop <= CW'(req_c);
          end
        end
      end
      ST_SCAN:  cnt <= cnt + CW'(1);
      ST_SH_WR: cnt <= down ? cnt - CW'(1) : cnt + CW'(1);
      default: ;
    endcase
  end

endmodule

// ===== design/window_layer_zorder_manager.sv =====
// Each operation is read, then decided; most operations give their first result
// from the decision. Allocate scans one layer per cycle for a free layer; a level
// change or a free of a shown layer first shifts each affected stacking entry with
// a read and a write. The next item is accepted the cycle after the last beat leaves.
// One operation at a time: in_stall is high whenever the controller is not idle.
// Reset (rst, synchronous): no layer in use, none shown, screen 640 x 480.
module window_layer_zorder_manager (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic [7:0]         layer,
  input  logic signed [12:0] pos_x,
  input  logic signed [12:0] pos_y,
  input  logic [12:0]        width,
  input  logic [12:0]        height_px,
  input  logic signed [10:0] new_level,
  input  logic signed [8:0]  key_color,
  input  logic [11:0]        rect_x0,
  input  logic [11:0]        rect_y0,
  input  logic [11:0]        rect_x1,
  input  logic [11:0]        rect_y1,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic [7:0]         given_layer,
  output logic               dirty_valid,
  output logic [12:0]        dirty_x0,
  output logic [12:0]        dirty_y0,
  output logic [12:0]        dirty_x1,
  output logic [12:0]        dirty_y1,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data
);
  import wlz_pkg::*;

  screen_t scr;
  item_t   item;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scr.w <= 13'd640;
      scr.h <= 13'd480;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  scr.w <= cfg_data;
        CFG_SCREEN_HEIGHT: scr.h <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item = '{func: func, layer: layer, pos_x: pos_x, pos_y: pos_y, width: width,
                  height_px: height_px, new_level: new_level, key_color: key_color,
                  rect_x0: rect_x0, rect_y0: rect_y0, rect_x1: rect_x1,
                  rect_y1: rect_y1};

  wlz_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .item      (item),
    .scr       (scr),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign status      = res.status;
  assign given_layer = res.given_layer;
  assign dirty_valid = res.dirty_valid;
  assign dirty_x0    = res.dirty_x0;
  assign dirty_y0    = res.dirty_y0;
  assign dirty_x1    = res.dirty_x1;
  assign dirty_y1    = res.dirty_y1;
  assign last        = res.last;

endmodule
